@@ hw/rtl/lbsm_pkg.sv @@
// Shared constants and types for the LRU block slot mapper.
`timescale 1ns / 1ps

package lbsm_pkg;

   localparam int CACHE_SLOTS = 64;
   localparam int ID_BITS     = 24;
   localparam int IDX_BITS    = $clog2(CACHE_SLOTS);

   localparam int BLOCK_ID_W  = 24;
   localparam int SLOT_W      = 6;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 8;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the request beat's block id
      logic lookup;    // compare tags, pick hit or victim slot
      logic commit;    // update tags/ranks, load the result register
   } ctrl_cmd_type;

endpackage

@@ hw/rtl/lru_block_slot_mapper_top.sv @@
// Top level of the LRU block slot mapper: controller plus datapath.
`timescale 1ns / 1ps
//
// Fully associative tag store with least-recently-used replacement.
// Request channel (req_*): one beat carries a block id. Result channel
// (rsp_*): one beat per request, hit flag and slot index.
// Each request is looked up against all valid tags at once; a hit reports
// its slot and makes it most recent, a miss takes the least recent slot,
// binds the id to it and reports hit = 0 so the caller fills the slot.
// An accepted request passes through the lookup state (parallel tag
// compare) and then the rank update state, which loads the result
// into the output register. A new request is taken in the same cycle
// the previous one retires.
// Reset (synchronous, active high) marks every slot invalid and sets the
// recency order to slot 0 least recent up to the last slot most recent,
// all at once; there is no clearing pass.
// When the receiver stalls, the result is held in its output register;
// one further request may be accepted and is held finished in the update
// step until the output register frees up.
//

module lru_block_slot_mapper_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lbsm_pkg::REQ_DATA_W-1:0]    req_tdata,   // [23:0] block_id
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lbsm_pkg::RSP_DATA_W-1:0]    rsp_tdata    // [0] hit, [6:1] slot, [7] zero
);
   import lbsm_pkg::*;

   ctrl_cmd_type      cmd;
   logic              rsp_hit;
   logic [SLOT_W-1:0] rsp_slot;

   lbsm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   lbsm_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_block_id (req_tdata[BLOCK_ID_W-1:0]),
      .rsp_hit      (rsp_hit),
      .rsp_slot     (rsp_slot)
   );

   assign rsp_tdata = {{(RSP_DATA_W - SLOT_W - 1){1'b0}}, rsp_slot, rsp_hit};

endmodule

@@ hw/rtl/lbsm_ctrl.sv @@
// Controller state machine for the LRU block slot mapper.
`timescale 1ns / 1ps

module lbsm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output lbsm_pkg::ctrl_cmd_type cmd
);
   import lbsm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOK   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;
   logic      commit;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) || ((state_ff == ST_UPDATE) && out_free);
   assign accept     = req_tvalid && req_tready;
   assign commit     = (state_ff == ST_UPDATE) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // take the next beat in the same cycle the current one retires
            if (commit) state_in = accept ? ST_LOOK : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign cmd.capture = accept;
   assign cmd.lookup  = (state_ff == ST_LOOK);
   assign cmd.commit  = commit;

`ifndef ASSERT_OFF
   a_commit_loads: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("result register not loaded on commit");
   a_look_then_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) |=> (state_ff == ST_UPDATE))
      else $error("lookup not followed by update");
   a_no_accept_in_look: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) |-> !req_tready)
      else $error("request taken during lookup");
`endif

endmodule

@@ hw/rtl/lbsm_datapath.sv @@
// Tag store, recency ranks and result register for the LRU block slot mapper.
`timescale 1ns / 1ps

module lbsm_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  lbsm_pkg::ctrl_cmd_type           cmd,
   input  logic [lbsm_pkg::BLOCK_ID_W-1:0]  req_block_id,
   output logic                             rsp_hit,
   output logic [lbsm_pkg::SLOT_W-1:0]      rsp_slot
);
   import lbsm_pkg::*;

   logic [ID_BITS+BLOCK_ID_W-1:0] id_ext;
   logic [ID_BITS-1:0]            id_ff;

   logic [ID_BITS-1:0]            tag_ff   [CACHE_SLOTS];
   logic [CACHE_SLOTS-1:0]        valid_ff;
   logic [IDX_BITS-1:0]           rank_ff  [CACHE_SLOTS];

   logic [CACHE_SLOTS-1:0]        match_vec;
   logic [CACHE_SLOTS-1:0]        lru_vec;
   logic [CACHE_SLOTS-1:0]        sel_ff;
   logic                          hit_ff;

   logic [IDX_BITS-1:0]           sel_idx;
   logic [IDX_BITS-1:0]           old_rank;
   logic [IDX_BITS+SLOT_W-1:0]    slot_ext;

   logic                          out_hit_ff;
   logic [SLOT_W-1:0]             out_slot_ff;

   // only the low ID_BITS of the block id take part in the compare
   assign id_ext = {{ID_BITS{1'b0}}, req_block_id};

   always_ff @(posedge clock) begin
      if (cmd.capture) id_ff <= id_ext[ID_BITS-1:0];
   end

   always_comb begin
      for (int i = 0; i < CACHE_SLOTS; i++) begin
         match_vec[i] = valid_ff[i] && (tag_ff[i] == id_ff);
         lru_vec[i]   = (rank_ff[i] == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_ff <= |match_vec;
         sel_ff <= (|match_vec) ? match_vec : lru_vec;
      end
   end

   // sel_ff is one-hot: OR-reduce to get the index and its current rank
   always_comb begin
      sel_idx  = '0;
      old_rank = '0;
      for (int i = 0; i < CACHE_SLOTS; i++) begin
         if (sel_ff[i]) begin
            sel_idx  = sel_idx | IDX_BITS'(i);
            old_rank = old_rank | rank_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < CACHE_SLOTS; i++) begin
            rank_ff[i] <= IDX_BITS'(i);
         end
      end else if (cmd.commit) begin
         for (int i = 0; i < CACHE_SLOTS; i++) begin
            if (sel_ff[i]) begin
               rank_ff[i] <= IDX_BITS'(CACHE_SLOTS - 1);
               if (!hit_ff) valid_ff[i] <= 1'b1;
            end else if (rank_ff[i] > old_rank) begin
               rank_ff[i] <= rank_ff[i] - 1'b1;
            end
         end
      end
   end

   // tags carry no reset; an entry is only compared once its valid bit is set
   always_ff @(posedge clock) begin
      if (cmd.commit && !hit_ff) begin
         for (int i = 0; i < CACHE_SLOTS; i++) begin
            if (sel_ff[i]) tag_ff[i] <= id_ff;
         end
      end
   end

   assign slot_ext = {{SLOT_W{1'b0}}, sel_idx};

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_hit_ff  <= hit_ff;
         out_slot_ff <= slot_ext[SLOT_W-1:0];
      end
   end

   assign rsp_hit  = out_hit_ff;
   assign rsp_slot = out_slot_ff;

`ifndef ASSERT_OFF
   a_lru_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot(lru_vec))
      else $error("recency ranks are not a permutation");
   a_tags_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("block id held in more than one slot");
   a_sel_onehot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $onehot(sel_ff))
      else $error("commit without a single selected slot");
   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && hit_ff) |-> (|(sel_ff & valid_ff)))
      else $error("hit reported on an invalid slot");
   a_commit_mru: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (|(sel_ff & ~lru_vec)) || (CACHE_SLOTS == 1))
      else $error("committed slot still least recent");
`endif

endmodule
